### rtl/sq8l2_pkg.sv
`default_nettype none

package sq8l2_pkg;

   // Parameter defaults
   localparam int MAX_DIMS_DEF  = 1024;
   localparam int FRAC_BITS_DEF = 16;

   // Fixed field widths
   localparam int IDX_W   = 10;
   localparam int VAL_W   = 32;
   localparam int CODE_W  = 8;
   localparam int DIST_W  = 63;
   localparam int LIMIT_W = 17;   // holds any MAX_DIMS value below 2**17

   // Datapath widths
   localparam int DIVX_W = CODE_W + VAL_W + 1;   // code*scale + bias
   localparam int DIVH_W = DIVX_W - 8;           // high part in the /255 reduction
   localparam int DIFF_W = VAL_W + 4;            // query - (min + offset)
   localparam int MAG_W  = 34;                   // |difference|

   localparam int Q_DEPTH = 4;

   localparam logic [7:0] ROUND_BIAS = 8'd127;
   localparam logic [7:0] DIV_RESID  = 8'd255;

   typedef enum logic {
      CMD_LOAD = 1'b0,
      CMD_ELEM = 1'b1
   } cmd_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_MUL,
      BK_DIV,
      BK_DIFF,
      BK_ABS,
      BK_SQ,
      BK_ACC
   } back_state_type;

   typedef enum logic [1:0] {
      SQ_LO_LO,
      SQ_HI_LO,
      SQ_HI_HI
   } sq_step_type;

   // One element word handed from the front to the back
   typedef struct packed {
      logic [VAL_W-1:0]  query;
      logic [CODE_W-1:0] code;
      logic [VAL_W-1:0]  minimum;
      logic [VAL_W-1:0]  scale;
      logic              last;
   } elem_type;

endpackage

`default_nettype wire

### rtl/sq8l2_front.sv
`default_nettype none

module sq8l2_front #(
   parameter int MAX_DIMS = sq8l2_pkg::MAX_DIMS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic                           req_cmd,
   input  logic [sq8l2_pkg::IDX_W-1:0]    req_dim_index,
   input  logic [sq8l2_pkg::VAL_W-1:0]    req_query_value,
   input  logic [sq8l2_pkg::CODE_W-1:0]   req_code,
   input  logic [sq8l2_pkg::VAL_W-1:0]    req_param_min,
   input  logic [sq8l2_pkg::VAL_W-1:0]    req_param_scale,
   input  logic                           req_last,
   output logic                           push,
   output sq8l2_pkg::elem_type            push_data,
   input  logic                           q_full
);
   import sq8l2_pkg::*;

   localparam int DEPTH = (MAX_DIMS < (2 ** IDX_W)) ? MAX_DIMS : (2 ** IDX_W);
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [VAL_W-1:0] min_mem   [DEPTH];
   logic [VAL_W-1:0] scale_mem [DEPTH];

   logic [VAL_W-1:0]  min_rd_ff, scale_rd_ff;
   logic              s1_valid_ff, s1_valid_in;
   logic [VAL_W-1:0]  s1_query_ff;
   logic [CODE_W-1:0] s1_code_ff;
   logic              s1_last_ff;
   logic              s1_ok_ff;

   logic          accept, in_range, is_elem;
   logic [AW-1:0] addr;

   assign req_stall = s1_valid_ff && q_full;
   assign accept    = req_valid && !req_stall;
   assign is_elem   = (req_cmd == CMD_ELEM);
   assign in_range  = (LIMIT_W'(req_dim_index) < LIMIT_W'(MAX_DIMS));
   assign addr      = req_dim_index[AW-1:0];
   assign push      = s1_valid_ff && !q_full;

   // tables: write on load, registered read on element
   always_ff @(posedge clock) begin
      if (accept && !is_elem && in_range) begin
         min_mem[addr]   <= req_param_min;
         scale_mem[addr] <= req_param_scale;
      end
      if (accept && is_elem) begin
         min_rd_ff   <= min_mem[addr];
         scale_rd_ff <= scale_mem[addr];
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (push) begin
         s1_valid_in = 1'b0;
      end
      if (accept && is_elem) begin
         s1_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && is_elem) begin
         s1_query_ff <= req_query_value;
         s1_code_ff  <= req_code;
         s1_last_ff  <= req_last;
         s1_ok_ff    <= in_range;
      end
   end

   // out-of-range index reads as min 0, scale 0
   always_comb begin
      push_data.query   = s1_query_ff;
      push_data.code    = s1_code_ff;
      push_data.minimum = s1_ok_ff ? min_rd_ff : '0;
      push_data.scale   = s1_ok_ff ? scale_rd_ff : '0;
      push_data.last    = s1_last_ff;
   end

endmodule

`default_nettype wire

### rtl/sq8l2_queue.sv
`default_nettype none

module sq8l2_queue #(
   parameter int DEPTH = sq8l2_pkg::Q_DEPTH
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  sq8l2_pkg::elem_type  push_data,
   output logic                 full,
   input  logic                 pop,
   output sq8l2_pkg::elem_type  pop_data,
   output logic                 empty
);
   import sq8l2_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   elem_type       entry [DEPTH];
   logic [PW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]  count_ff, count_in;

   assign full     = (count_ff == CW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = entry[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

### rtl/sq8l2_back.sv
`default_nettype none

module sq8l2_back #(
   parameter int FRAC_BITS = sq8l2_pkg::FRAC_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          q_empty,
   input  sq8l2_pkg::elem_type           pop_data,
   output logic                          pop,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [sq8l2_pkg::DIST_W-1:0]  rsp_distance,
   output logic                          rsp_saturated
);
   import sq8l2_pkg::*;

   localparam int HI_W   = MAG_W - FRAC_BITS;
   localparam int MW     = (HI_W > FRAC_BITS) ? HI_W : FRAC_BITS;
   localparam int PROD_W = 2 * MW;
   localparam int SQ_W   = 2 * MAG_W - FRAC_BITS;

   back_state_type    state_ff, state_in;
   sq_step_type       step_ff, step_in;

   logic [VAL_W-1:0]  query_ff, query_in;
   logic [CODE_W-1:0] code_ff, code_in;
   logic [VAL_W-1:0]  min_ff, min_in;
   logic [VAL_W-1:0]  scale_ff, scale_in;
   logic              last_ff, last_in;
   logic [DIVX_W-1:0] x_ff, x_in;
   logic [VAL_W-1:0]  q_ff, q_in;
   logic [DIFF_W-1:0] diff_ff, diff_in;
   logic [MAG_W-1:0]  mag_ff, mag_in;
   logic [SQ_W-1:0]   sq_ff, sq_in;
   logic [DIST_W-1:0] acc_ff, acc_in;
   logic              clip_ff, clip_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [DIST_W-1:0] dist_ff, dist_in;
   logic              sat_ff, sat_in;

   logic [DIVX_W-2:0] cs_prod;
   logic [DIVH_W-1:0] x_hi;
   logic [7:0]        x_lo;
   logic [DIFF_W-1:0] diff_neg;
   logic [HI_W-1:0]   m_hi;
   logic [FRAC_BITS-1:0] m_lo;
   logic [MW-1:0]     mul_a, mul_b;
   logic [PROD_W-1:0] mul_p;
   logic [DIST_W:0]   acc_sum;
   logic              acc_sat;
   logic [DIST_W-1:0] acc_next;
   logic              clip_next;
   logic              out_free;

   assign cs_prod  = code_ff * scale_ff;
   assign x_hi     = x_ff[DIVX_W-1:8];
   assign x_lo     = x_ff[7:0];
   assign diff_neg = '0 - diff_ff;
   assign m_hi     = mag_ff[MAG_W-1:FRAC_BITS];
   assign m_lo     = mag_ff[FRAC_BITS-1:0];
   assign mul_p    = mul_a * mul_b;

   assign acc_sum   = {1'b0, acc_ff} + (DIST_W + 1)'(sq_ff);
   assign acc_sat   = acc_sum[DIST_W];
   assign acc_next  = acc_sat ? '1 : acc_sum[DIST_W-1:0];
   assign clip_next = clip_ff | acc_sat;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_distance  = dist_ff;
   assign rsp_saturated = sat_ff;

   always_comb begin
      mul_a = MW'(m_hi);
      mul_b = MW'(m_hi);
      case (step_ff)
         SQ_LO_LO: begin
            mul_a = MW'(m_lo);
            mul_b = MW'(m_lo);
         end
         SQ_HI_LO: begin
            mul_a = MW'(m_hi);
            mul_b = MW'(m_lo);
         end
         default: begin
            mul_a = MW'(m_hi);
            mul_b = MW'(m_hi);
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      query_in     = query_ff;
      code_in      = code_ff;
      min_in       = min_ff;
      scale_in     = scale_ff;
      last_in      = last_ff;
      x_in         = x_ff;
      q_in         = q_ff;
      diff_in      = diff_ff;
      mag_in       = mag_ff;
      sq_in        = sq_ff;
      acc_in       = acc_ff;
      clip_in      = clip_ff;
      dist_in      = dist_ff;
      sat_in       = sat_ff;
      pop          = 1'b0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      case (state_ff)
         BK_IDLE: begin
            if (!q_empty) begin
               pop      = 1'b1;
               query_in = pop_data.query;
               code_in  = pop_data.code;
               min_in   = pop_data.minimum;
               scale_in = pop_data.scale;
               last_in  = pop_data.last;
               state_in = BK_MUL;
            end
         end
         BK_MUL: begin
            x_in     = {1'b0, cs_prod} + DIVX_W'(ROUND_BIAS);
            q_in     = '0;
            state_in = BK_DIV;
         end
         BK_DIV: begin
            // x = 256h + l = 255h + (h + l)
            if (x_hi == '0) begin
               q_in     = q_ff + ((x_lo == DIV_RESID) ? VAL_W'(1) : VAL_W'(0));
               state_in = BK_DIFF;
            end else begin
               q_in = q_ff + x_hi[VAL_W-1:0];
               x_in = DIVX_W'(x_hi) + DIVX_W'(x_lo);
            end
         end
         BK_DIFF: begin
            diff_in  = {{(DIFF_W - VAL_W){query_ff[VAL_W-1]}}, query_ff}
                     - {{(DIFF_W - VAL_W){min_ff[VAL_W-1]}}, min_ff}
                     - DIFF_W'(q_ff);
            state_in = BK_ABS;
         end
         BK_ABS: begin
            mag_in   = diff_ff[DIFF_W-1] ? diff_neg[MAG_W-1:0] : diff_ff[MAG_W-1:0];
            step_in  = SQ_LO_LO;
            state_in = BK_SQ;
         end
         BK_SQ: begin
            case (step_ff)
               SQ_LO_LO: begin
                  sq_in   = SQ_W'(mul_p >> FRAC_BITS);
                  step_in = SQ_HI_LO;
               end
               SQ_HI_LO: begin
                  sq_in   = sq_ff + SQ_W'({mul_p, 1'b0});
                  step_in = SQ_HI_HI;
               end
               default: begin
                  sq_in    = sq_ff + (SQ_W'(mul_p) << FRAC_BITS);
                  state_in = BK_ACC;
               end
            endcase
         end
         BK_ACC: begin
            if (!last_ff) begin
               acc_in   = acc_next;
               clip_in  = clip_next;
               state_in = BK_IDLE;
            end else if (out_free) begin
               rsp_valid_in = 1'b1;
               dist_in      = acc_next;
               sat_in       = clip_next;
               acc_in       = '0;
               clip_in      = 1'b0;
               state_in     = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         step_ff      <= SQ_LO_LO;
         acc_ff       <= '0;
         clip_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         acc_ff       <= acc_in;
         clip_ff      <= clip_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      query_ff <= query_in;
      code_ff  <= code_in;
      min_ff   <= min_in;
      scale_ff <= scale_in;
      last_ff  <= last_in;
      x_ff     <= x_in;
      q_ff     <= q_in;
      diff_ff  <= diff_in;
      mag_ff   <= mag_in;
      sq_ff    <= sq_in;
      dist_ff  <= dist_in;
      sat_ff   <= sat_in;
   end

endmodule

`default_nettype wire

### rtl/sq8_asymmetric_l2_distance.sv
// Channel  Direction  Handshake             Word
// req_     in         req_valid/req_stall   cmd, dim_index, query_value, code,
//                                           param_min, param_scale, last
// rsp_     out        rsp_valid/rsp_stall   distance, saturated
//
// A load word is a table write in the front. An element word goes through the
// back: the divide-by-255 reduction repeats until its high part is zero, then the
// three-pass shared square multiplier runs, and the sum is accumulated.
// The back handles one element at a time; the front and a 4-word queue keep
// accepting meanwhile. Reset is synchronous, active high; tables are not cleared.
// rsp_stall holds the result register and the back waits; req_stall rises only
// when the queue is full and the front stage is occupied.

`default_nettype none

module sq8_asymmetric_l2_distance #(
   parameter int MAX_DIMS  = sq8l2_pkg::MAX_DIMS_DEF,
   parameter int FRAC_BITS = sq8l2_pkg::FRAC_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_cmd,
   input  logic [sq8l2_pkg::IDX_W-1:0]          req_dim_index,
   input  logic signed [sq8l2_pkg::VAL_W-1:0]   req_query_value,
   input  logic [sq8l2_pkg::CODE_W-1:0]         req_code,
   input  logic signed [sq8l2_pkg::VAL_W-1:0]   req_param_min,
   input  logic [sq8l2_pkg::VAL_W-1:0]          req_param_scale,
   input  logic                                 req_last,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [sq8l2_pkg::DIST_W-1:0]         rsp_distance,
   output logic                                 rsp_saturated
);
   import sq8l2_pkg::*;

   // front -> queue
   logic     push;
   elem_type push_data;
   logic     q_full;

   // queue -> back
   logic     pop;
   elem_type pop_data;
   logic     q_empty;

   // Front: classifies words, owns the min/scale tables, reads them for elements
   sq8l2_front #(
      .MAX_DIMS (MAX_DIMS)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_cmd         (req_cmd),
      .req_dim_index   (req_dim_index),
      .req_query_value (req_query_value),
      .req_code        (req_code),
      .req_param_min   (req_param_min),
      .req_param_scale (req_param_scale),
      .req_last        (req_last),
      .push            (push),
      .push_data       (push_data),
      .q_full          (q_full)
   );

   // Decoupling queue between table lookup and arithmetic
   sq8l2_queue #(
      .DEPTH (Q_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (q_full),
      .pop       (pop),
      .pop_data  (pop_data),
      .empty     (q_empty)
   );

   // Back: dequantize, difference, square, saturating accumulate, result register
   sq8l2_back #(
      .FRAC_BITS (FRAC_BITS)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .q_empty       (q_empty),
      .pop_data      (pop_data),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_distance  (rsp_distance),
      .rsp_saturated (rsp_saturated)
   );

endmodule

`default_nettype wire

### rtl/sq8l2_checker.sv
`default_nettype none

module sq8l2_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          rsp_valid,
   input  logic                          rsp_stall,
   input  logic [sq8l2_pkg::DIST_W-1:0]  rsp_distance,
   input  logic                          rsp_saturated
);
   import sq8l2_pkg::*;

   // nothing comes out right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result word valid right after reset");

   // a clipped distance is pinned at full scale
   a_sat_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_saturated) |-> (rsp_distance == {DIST_W{1'b1}}))
      else $error("saturated result below full scale");

   a_hold_valid: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid)
      else $error("result word dropped while stalled");

   a_hold_data: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> ($stable(rsp_distance) && $stable(rsp_saturated)))
      else $error("result word changed while stalled");

endmodule

bind sq8_asymmetric_l2_distance sq8l2_checker u_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_distance  (rsp_distance),
   .rsp_saturated (rsp_saturated)
);

`default_nettype wire

### tb/sv/sq8_asymmetric_l2_distance_test.sv
`timescale 1ns / 100ps

// Squared-L2 check of the SQ8 distance block.
// Words go in on req_ (loads fill the min/scale tables, elements accumulate),
// distances come back on rsp_. A shadow copy of the tables and accumulator
// predicts every distance; the checker pops them in order.

module sq8_asymmetric_l2_distance_test;
   import sq8l2_pkg::*;

   localparam logic [VAL_W-1:0] Q_MIN = 32'h8000_0000;
   localparam logic [VAL_W-1:0] Q_MAX = 32'h7FFF_FFFF;
   localparam logic [VAL_W-1:0] U_MAX = 32'hFFFF_FFFF;
   localparam int RANDOM_WORDS = 1450;
   localparam int HOLD_CYCLES  = 300;   // long rsp_stall stretch to fill the queue

   typedef enum logic [1:0] {
      RX_OPEN,
      RX_RANDOM,
      RX_BURSTY
   } rx_mode_type;

   // one request word as the sender sees it
   typedef struct {
      cmd_type                  cmd;
      logic [IDX_W-1:0]         idx;
      logic signed [VAL_W-1:0]  query;
      logic [CODE_W-1:0]        code;
      logic signed [VAL_W-1:0]  pmin;
      logic [VAL_W-1:0]         pscale;
      logic                     last;
   } dim_word_type;

   typedef struct {
      logic [DIST_W-1:0] distance;
      logic              saturated;
   } dist_rec_type;

   // ---------------------------------------------------------------- DUT I/O
   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic                     req_cmd = 1'b0;
   logic [IDX_W-1:0]         req_dim_index = '0;
   logic signed [VAL_W-1:0]  req_query_value = '0;
   logic [CODE_W-1:0]        req_code = '0;
   logic signed [VAL_W-1:0]  req_param_min = '0;
   logic [VAL_W-1:0]         req_param_scale = '0;
   logic                     req_last = 1'b0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic [DIST_W-1:0]        rsp_distance;
   logic                     rsp_saturated;

   sq8_asymmetric_l2_distance i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_cmd         (req_cmd),
      .req_dim_index   (req_dim_index),
      .req_query_value (req_query_value),
      .req_code        (req_code),
      .req_param_min   (req_param_min),
      .req_param_scale (req_param_scale),
      .req_last        (req_last),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_distance    (rsp_distance),
      .rsp_saturated   (rsp_saturated)
   );

   always #6 clock = ~clock;

   // ------------------------------------------------------- shadow state
   logic signed [VAL_W-1:0] min_tab   [MAX_DIMS_DEF];
   logic [VAL_W-1:0]        scale_tab [MAX_DIMS_DEF];
   bit                      is_loaded [MAX_DIMS_DEF];
   int                      loaded_dims[$];   // only these may be read by elements
   logic [DIST_W-1:0]       acc_sum = '0;
   logic                    acc_clipped = 1'b0;
   dist_rec_type            pending_distances[$];
   int                      mismatches = 0;

   // sender / receiver idling knobs
   bit          tx_gaps_on = 1'b0;
   int          burst_left = 0;
   rx_mode_type rx_mode = RX_OPEN;
   bit          hold_armed = 1'b0;   // toggled by a test, seen by the receiver
   bit          hold_seen = 1'b0;
   int          hold_left = 0;
   int          run_left = 0;
   bit          run_stalled = 1'b0;

   // Update the shadow state with one accepted word; queue a distance on last.
   function automatic void accumulate_distance(input dim_word_type w);
      logic [39:0]        prod;
      logic [39:0]        off;
      logic signed [35:0] base;
      logic signed [35:0] delta;
      logic [33:0]        mag;
      logic [67:0]        sq;
      logic [63:0]        sum;
      if (w.cmd == CMD_LOAD) begin
         // last is don't-care on a load
         min_tab[w.idx]   = w.pmin;
         scale_tab[w.idx] = w.pscale;
         if (!is_loaded[w.idx]) begin
            is_loaded[w.idx] = 1'b1;
            loaded_dims.push_back(int'(w.idx));
         end
         return;
      end
      // dequantize: min + round(code*scale/255), never an exact half
      prod  = 40'(w.code) * 40'(scale_tab[w.idx]);
      off   = (prod + 40'd127) / 40'd255;
      base  = 36'(min_tab[w.idx]) + 36'(off);
      delta = 36'(w.query) - base;
      mag   = delta[35] ? 34'(-delta) : 34'(delta);
      sq    = 68'(mag) * 68'(mag);
      sum   = 64'(acc_sum) + 64'(sq >> FRAC_BITS_DEF);
      if (sum > {1'b0, {DIST_W{1'b1}}}) begin
         acc_sum     = '1;   // pin at full scale
         acc_clipped = 1'b1;
      end else begin
         acc_sum = sum[DIST_W-1:0];
      end
      if (w.last) begin
         pending_distances.push_back('{distance: acc_sum, saturated: acc_clipped});
         acc_sum     = '0;
         acc_clipped = 1'b0;
      end
   endfunction

   // Word builders; fields the block ignores still get random bits.
   function automatic dim_word_type load_word(input logic [IDX_W-1:0] idx,
                                              input logic [VAL_W-1:0] pmin,
                                              input logic [VAL_W-1:0] pscale,
                                              input logic last);
      dim_word_type w;
      w.cmd    = CMD_LOAD;
      w.idx    = idx;
      w.query  = $urandom;
      w.code   = CODE_W'($urandom);
      w.pmin   = pmin;
      w.pscale = pscale;
      w.last   = last;
      return w;
   endfunction

   function automatic dim_word_type elem_word(input logic [IDX_W-1:0] idx,
                                              input logic [VAL_W-1:0] query,
                                              input logic [CODE_W-1:0] code,
                                              input logic last);
      dim_word_type w;
      w.cmd    = CMD_ELEM;
      w.idx    = idx;
      w.query  = query;
      w.code   = code;
      w.pmin   = $urandom;
      w.pscale = $urandom;
      w.last   = last;
      return w;
   endfunction

   function automatic dim_word_type any_load();
      return load_word(IDX_W'($urandom_range(0, MAX_DIMS_DEF - 1)), $urandom, $urandom,
                       $urandom_range(0, 9) == 0);
   endfunction

   function automatic logic [IDX_W-1:0] any_loaded_dim();
      return IDX_W'(loaded_dims[$urandom_range(0, loaded_dims.size() - 1)]);
   endfunction

   // ---------------------------------------------------------------- sender
   // Offers one word, holds it through req_stall, then predicts from it.
   // With gaps on, words go out in bursts with idle stretches between.
   task automatic send_word(input dim_word_type w);
      int gap;
      if (tx_gaps_on && burst_left == 0) begin
         gap        = $urandom_range(1, 8);
         burst_left = $urandom_range(1, 16);
         repeat (gap) begin
            @(negedge clock);
            req_valid <= 1'b0;
            req_cmd   <= 1'($urandom);   // payload is free while idle
            req_last  <= 1'($urandom);
         end
      end
      if (burst_left > 0)
         burst_left--;
      @(negedge clock);
      req_valid       <= 1'b1;
      req_cmd         <= w.cmd;
      req_dim_index   <= w.idx;
      req_query_value <= w.query;
      req_code        <= w.code;
      req_param_min   <= w.pmin;
      req_param_scale <= w.pscale;
      req_last        <= w.last;
      do
         @(posedge clock);
      while (req_stall);
      accumulate_distance(w);
   endtask

   // -------------------------------------------------------------- receiver
   // Stall pattern of its own; a toggle of hold_armed starts a long hold-off.
   always @(negedge clock) begin
      if (hold_armed != hold_seen) begin
         hold_seen = hold_armed;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         case (rx_mode)
            RX_OPEN: begin
               rsp_stall <= 1'b0;
            end
            RX_RANDOM: begin
               rsp_stall <= ($urandom_range(0, 2) == 0);
            end
            default: begin
               // alternating runs of stall / no stall
               if (run_left == 0) begin
                  run_stalled = !run_stalled;
                  run_left    = $urandom_range(1, 24);
               end
               run_left--;
               rsp_stall <= run_stalled;
            end
         endcase
      end
   end

   // --------------------------------------------------------------- checker
   always @(posedge clock) begin : check_results
      dist_rec_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_distances.size() == 0) begin
            $error("unexpected result word: distance %0d saturated %0d",
                   rsp_distance, rsp_saturated);
            mismatches++;
         end else begin
            want = pending_distances.pop_front();
            if (rsp_distance !== want.distance) begin
               $error("distance: expected %0d, got %0d", want.distance, rsp_distance);
               mismatches++;
            end
            if (rsp_saturated !== want.saturated) begin
               $error("saturated: expected %0d, got %0d", want.saturated, rsp_saturated);
               mismatches++;
            end
         end
      end
   end

   // ----------------------------------------------------------------- tests
   // Field extremes, both commands, load with last set, zero distance,
   // rounding of the dequantized value, single- and multi-element vectors.
   task automatic test_directed_cases();
      tx_gaps_on = 1'b0;
      rx_mode    = RX_OPEN;
      send_word(load_word(10'd0, Q_MIN, U_MAX, 1'b0));
      send_word(load_word(10'd1023, Q_MAX, '0, 1'b0));
      send_word(load_word(10'd512, '0, U_MAX, 1'b0));
      send_word(load_word(10'd341, $urandom, $urandom, 1'b0));   // alternating index bits
      send_word(load_word(10'd682, $urandom, $urandom, 1'b0));
      send_word(load_word(10'd2, Q_MAX, U_MAX, 1'b1));           // last on a load: no word out
      send_word(elem_word(10'd0, Q_MAX, 8'd0, 1'b0));
      send_word(elem_word(10'd0, Q_MIN, 8'd255, 1'b0));
      send_word(elem_word(10'd1023, Q_MIN, 8'd255, 1'b1));
      send_word(elem_word(10'd2, Q_MIN, 8'd255, 1'b1));          // largest single square
      send_word(elem_word(10'd512, '0, 8'd0, 1'b1));             // zero distance
      send_word(elem_word(10'd512, '0, 8'd128, 1'b1));           // quotient is exact, no rounding
      send_word(elem_word(10'd341, $urandom, 8'd1, 1'b0));
      send_word(elem_word(10'd682, $urandom, 8'd254, 1'b1));
      // scale 255.0: code maps to whole units
      send_word(load_word(10'd0, '0, 32'h00FF_0000, 1'b0));
      send_word(elem_word(10'd0, 32'h0001_0000, 8'd1, 1'b1));
   endtask

   // Drive the accumulator into its ceiling, then check the flag clears.
   task automatic test_accumulator_clip();
      tx_gaps_on = 1'b1;
      rx_mode    = RX_RANDOM;
      send_word(load_word(10'd3, Q_MAX, U_MAX, 1'b0));
      while (!acc_clipped)
         send_word(elem_word(10'd3, Q_MIN, 8'd255, 1'b0));
      repeat (3)
         send_word(elem_word(10'd3, Q_MIN, 8'd255, 1'b0));
      send_word(elem_word(10'd3, Q_MIN, 8'd255, 1'b1));
      send_word(elem_word(10'd512, $urandom, 8'd7, 1'b1));
   endtask

   // Receiver holds off while short vectors keep coming: the result register,
   // the back end and the queue fill and req_stall has to rise.
   task automatic test_result_backpressure();
      tx_gaps_on = 1'b0;
      rx_mode    = RX_OPEN;
      hold_armed = !hold_armed;
      repeat (12)
         send_word(elem_word(any_loaded_dim(), $urandom, CODE_W'($urandom), 1'b1));
      rx_mode = RX_BURSTY;
   endtask

   // Mostly well-formed vectors with random content; stray loads (some with
   // last set) land between and inside vectors.
   task automatic test_random_traffic();
      int sent;
      int len;
      int k;
      logic [VAL_W-1:0]  query;
      logic [CODE_W-1:0] code;
      sent = 0;
      while (sent < RANDOM_WORDS) begin
         if ($urandom_range(0, 5) == 0) begin
            tx_gaps_on = 1'($urandom_range(0, 1));
            rx_mode    = rx_mode_type'($urandom_range(0, 2));
         end
         if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 4)) begin
               send_word(any_load());
               sent++;
            end
         end
         len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 48) : $urandom_range(1, 12);
         for (k = 0; k < len; k++) begin
            if ($urandom_range(0, 15) == 0) begin
               send_word(any_load());
               sent++;
            end
            case ($urandom_range(0, 7))
               0:       code = 8'd0;
               1:       code = 8'd255;
               default: code = CODE_W'($urandom);
            endcase
            // half full-range queries, half small ones near zero
            if ($urandom_range(0, 1))
               query = $urandom;
            else
               query = 32'($urandom_range(0, 2097152)) - 32'h0010_0000;
            send_word(elem_word(any_loaded_dim(), query, code, k == len - 1));
            sent++;
         end
      end
   endtask

   // ------------------------------------------------------------------ main
   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed_cases();
      test_accumulator_clip();
      test_result_backpressure();
      test_random_traffic();
      @(negedge clock);
      req_valid <= 1'b0;
      rx_mode = RX_RANDOM;
      wait (pending_distances.size() == 0);
      repeat (40) @(posedge clock);   // trailing elements without last
      if (mismatches == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

   // watchdog, far beyond the slowest legal run
   initial begin
      #30_000_000;
      $display("FAIL");
      $finish;
   end

endmodule

### filelist.f
rtl/sq8l2_pkg.sv
rtl/sq8l2_front.sv
rtl/sq8l2_queue.sv
rtl/sq8l2_back.sv
rtl/sq8_asymmetric_l2_distance.sv
rtl/sq8l2_checker.sv
tb/sv/sq8_asymmetric_l2_distance_test.sv
